FILE: rtl/hpss_pkg.sv
// Shared types, constants and register codes for the heading PID steering and speed block.
`default_nettype none

package hpss_pkg;

	// Default width of the stored error integral.
	localparam int SUM_WIDTH_DEF = 24;

	// Configuration port geometry.
	localparam int ADDR_WIDTH = 5;
	localparam int DATA_WIDTH = 32;

	// Register reset values.
	localparam logic [11:0] GAIN_P_RST        = 12'd230;
	localparam logic [11:0] GAIN_I_RST        = 12'd0;
	localparam logic [11:0] GAIN_D_RST        = 12'd256;
	localparam logic [8:0]  FACING_RST        = 9'd0;
	localparam logic        GO_FORWARD_RST    = 1'b1;
	localparam logic [15:0] TARGET_PULSES_RST = 16'd1718;
	localparam logic [7:0]  PWM_MAX_RST       = 8'd200;
	localparam logic [7:0]  PWM_MIN_RST       = 8'd80;

	// Heading arithmetic, in degrees and in 1/16 degree.
	localparam logic [9:0]  REVERSE_OFFSET = 10'd180;
	localparam logic [9:0]  FULL_TURN_DEG  = 10'd360;
	localparam logic signed [15:0] HALF_TURN_Q4  = 16'sd2880;
	localparam logic signed [15:0] FULL_TURN_Q4  = 16'sd5760;
	localparam logic signed [15:0] ERR_MAX       = 16'sd4095;
	localparam logic signed [15:0] ERR_MIN       = -16'sd4096;

	// Servo arithmetic: correction is in 1/4096 degree.
	localparam int SERVO_BASE_Q12 = 85 * 4096;
	localparam int SERVO_MIN      = 50;
	localparam int SERVO_MAX      = 150;
	localparam logic [7:0] SERVO_DONE = 8'd90;

	// Register map, index = byte address / 4.
	typedef enum logic [2:0] {
		REG_GAIN_P        = 3'd0,
		REG_GAIN_I        = 3'd1,
		REG_GAIN_D        = 3'd2,
		REG_FACING_DEG    = 3'd3,
		REG_GO_FORWARD    = 3'd4,
		REG_TARGET_PULSES = 3'd5,
		REG_PWM_MAX       = 3'd6,
		REG_PWM_MIN       = 3'd7
	} reg_idx_t;

	// Motor direction codes.
	typedef enum logic [1:0] {
		DIR_STOP    = 2'd0,
		DIR_FORWARD = 2'd1,
		DIR_REVERSE = 2'd2
	} motor_dir_t;

	// Configuration register contents.
	typedef struct packed {
		logic [11:0] gain_p;
		logic [11:0] gain_i;
		logic [11:0] gain_d;
		logic [8:0]  facing_deg;
		logic        go_forward;
		logic [15:0] target_pulses;
		logic [7:0]  pwm_max;
		logic [7:0]  pwm_min;
	} cfg_t;

	// Load strobes of the pipeline stages.
	typedef struct packed {
		logic ld1;
		logic ld2;
		logic ld3;
		logic ld4;
	} pipe_ctl_t;

	// Error stage results handed to the multiply stage.
	typedef struct packed {
		logic              done;
		motor_dir_t        dir;
		logic [7:0]        pwm;
		logic signed [12:0] err;
		logic signed [13:0] deriv;
	} err_res_t;

	// Final result item.
	typedef struct packed {
		logic       done;
		motor_dir_t dir;
		logic [7:0] pwm;
		logic [7:0] servo;
	} out_res_t;

endpackage

`default_nettype wire

FILE: rtl/hpss_cfg.sv
// Configuration register file with its APB-style access port.
`default_nettype none

module hpss_cfg import hpss_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [ADDR_WIDTH-1:0] paddr,
	input  wire logic [DATA_WIDTH-1:0] pwdata,
	output logic      [DATA_WIDTH-1:0] prdata,
	output cfg_t                       cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx   = reg_idx_t'(paddr[4:2]);
	assign wr_en = psel && penable && pwrite;
	assign cfg   = cfg_q;

	// Register writes on the access cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_p        <= GAIN_P_RST;
			cfg_q.gain_i        <= GAIN_I_RST;
			cfg_q.gain_d        <= GAIN_D_RST;
			cfg_q.facing_deg    <= FACING_RST;
			cfg_q.go_forward    <= GO_FORWARD_RST;
			cfg_q.target_pulses <= TARGET_PULSES_RST;
			cfg_q.pwm_max       <= PWM_MAX_RST;
			cfg_q.pwm_min       <= PWM_MIN_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_GAIN_P:        cfg_q.gain_p        <= pwdata[11:0];
				REG_GAIN_I:        cfg_q.gain_i        <= pwdata[11:0];
				REG_GAIN_D:        cfg_q.gain_d        <= pwdata[11:0];
				REG_FACING_DEG:    cfg_q.facing_deg    <= pwdata[8:0];
				REG_GO_FORWARD:    cfg_q.go_forward    <= pwdata[0];
				REG_TARGET_PULSES: cfg_q.target_pulses <= pwdata[15:0];
				REG_PWM_MAX:       cfg_q.pwm_max       <= pwdata[7:0];
				REG_PWM_MIN:       cfg_q.pwm_min       <= pwdata[7:0];
			endcase
		end
	end

	// Read data selection.
	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_GAIN_P:        prdata = DATA_WIDTH'(cfg_q.gain_p);
			REG_GAIN_I:        prdata = DATA_WIDTH'(cfg_q.gain_i);
			REG_GAIN_D:        prdata = DATA_WIDTH'(cfg_q.gain_d);
			REG_FACING_DEG:    prdata = DATA_WIDTH'(cfg_q.facing_deg);
			REG_GO_FORWARD:    prdata = DATA_WIDTH'(cfg_q.go_forward);
			REG_TARGET_PULSES: prdata = DATA_WIDTH'(cfg_q.target_pulses);
			REG_PWM_MAX:       prdata = DATA_WIDTH'(cfg_q.pwm_max);
			REG_PWM_MIN:       prdata = DATA_WIDTH'(cfg_q.pwm_min);
		endcase
	end

endmodule

`default_nettype wire

FILE: rtl/hpss_err.sv
// Input register, heading error, integral state and motor duty stage.
`default_nettype none

module hpss_err import hpss_pkg::*; #(
	parameter int SUM_WIDTH = SUM_WIDTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  pipe_ctl_t                  ctl,
	input  cfg_t                       cfg,
	input  wire logic                  restart,
	input  wire logic [12:0]           heading,
	input  wire logic [15:0]           pulse_count,
	output err_res_t                   res,
	output logic signed [SUM_WIDTH-1:0] sum
);

	localparam logic signed [SUM_WIDTH:0] SUM_MAX = {2'b00, {(SUM_WIDTH-1){1'b1}}};
	localparam logic signed [SUM_WIDTH:0] SUM_MIN = {2'b11, {(SUM_WIDTH-1){1'b0}}};

	// Input register.
	logic        restart_s1;
	logic [12:0] heading_s1;
	logic [15:0] count_s1;

	// Controller state.
	logic signed [SUM_WIDTH-1:0] sum_q;
	logic signed [12:0]          prev_q;

	// Stage two outputs.
	err_res_t                    res_s2;
	logic signed [SUM_WIDTH-1:0] sum_s2;

	logic                        done;
	logic [9:0]                  sp_raw;
	logic [9:0]                  sp;
	logic signed [15:0]          err_raw;
	logic signed [15:0]          err_w1;
	logic signed [15:0]          err_w2;
	logic signed [12:0]          err;
	logic signed [SUM_WIDTH-1:0] base_sum;
	logic signed [12:0]          base_prev;
	logic signed [SUM_WIDTH:0]   sum_ext;
	logic signed [SUM_WIDTH-1:0] sum_next;
	logic signed [13:0]          deriv;
	logic [15:0]                 remain;
	logic [14:0]                 half;
	logic [7:0]                  pwm_hi;
	logic [7:0]                  pwm;

	always_ff @(posedge clk) begin
		if (ctl.ld1) begin
			restart_s1 <= restart;
			heading_s1 <= heading;
			count_s1   <= pulse_count;
		end
	end

	// Setpoint and heading error, wrapped once and then saturated.
	always_comb begin
		done   = count_s1 >= cfg.target_pulses;
		sp_raw = {1'b0, cfg.facing_deg};
		sp     = sp_raw;
		if (!cfg.go_forward) begin
			sp_raw = {1'b0, cfg.facing_deg} + REVERSE_OFFSET;
			sp     = (sp_raw > FULL_TURN_DEG) ? sp_raw - FULL_TURN_DEG : sp_raw;
		end
		err_raw = $signed({3'b000, heading_s1}) - $signed({2'b00, sp, 4'b0000});
		err_w1  = (err_raw > HALF_TURN_Q4) ? err_raw - FULL_TURN_Q4 : err_raw;
		err_w2  = (err_w1 < -HALF_TURN_Q4) ? err_w1 + FULL_TURN_Q4 : err_w1;
		if (err_w2 > ERR_MAX) begin
			err = ERR_MAX[12:0];
		end else if (err_w2 < ERR_MIN) begin
			err = ERR_MIN[12:0];
		end else begin
			err = err_w2[12:0];
		end
	end

	// Integral update with saturation; restart clears the state first.
	always_comb begin
		base_sum  = restart_s1 ? '0 : sum_q;
		base_prev = restart_s1 ? '0 : prev_q;
		sum_ext   = {base_sum[SUM_WIDTH-1], base_sum} + (SUM_WIDTH+1)'(err);
		if (sum_ext > SUM_MAX) begin
			sum_next = SUM_MAX[SUM_WIDTH-1:0];
		end else if (sum_ext < SUM_MIN) begin
			sum_next = SUM_MIN[SUM_WIDTH-1:0];
		end else begin
			sum_next = sum_ext[SUM_WIDTH-1:0];
		end
		deriv = 14'(err) - 14'(base_prev);
	end

	// Motor duty: half the remaining pulses, upper clamp then lower clamp.
	always_comb begin
		remain = cfg.target_pulses - count_s1;
		half   = remain[15:1];
		pwm_hi = (half > {7'd0, cfg.pwm_max}) ? cfg.pwm_max : half[7:0];
		pwm    = (pwm_hi < cfg.pwm_min) ? cfg.pwm_min : pwm_hi;
	end

	// State update as the item leaves the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q  <= '0;
			prev_q <= '0;
		end else if (ctl.ld2) begin
			if (done) begin
				sum_q  <= base_sum;
				prev_q <= base_prev;
			end else begin
				sum_q  <= sum_next;
				prev_q <= err;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ld2) begin
			res_s2.done  <= done;
			res_s2.dir   <= done ? DIR_STOP : (cfg.go_forward ? DIR_FORWARD : DIR_REVERSE);
			res_s2.pwm   <= done ? 8'd0 : pwm;
			res_s2.err   <= err;
			res_s2.deriv <= deriv;
			sum_s2       <= sum_next;
		end
	end

	assign res = res_s2;
	assign sum = sum_s2;

endmodule

`default_nettype wire

FILE: rtl/hpss_mix.sv
// PID products, correction sum and servo angle output register.
`default_nettype none

module hpss_mix import hpss_pkg::*; #(
	parameter int SUM_WIDTH = SUM_WIDTH_DEF
) (
	input  wire logic                   clk,
	input  pipe_ctl_t                   ctl,
	input  cfg_t                        cfg,
	input  err_res_t                    res_in,
	input  wire logic signed [SUM_WIDTH-1:0] sum,
	output out_res_t                    res
);

	localparam int CW = SUM_WIDTH + 16;
	localparam int QW = CW - 12;

	// Stage three: products.
	logic               done_s3;
	motor_dir_t         dir_s3;
	logic [7:0]         pwm_s3;
	logic signed [25:0] pp_s3;
	logic signed [SUM_WIDTH+12:0] pi_s3;
	logic signed [26:0] pd_s3;

	// Stage four: result register.
	out_res_t res_s4;

	logic signed [CW-1:0] corr;
	logic signed [CW-1:0] num;
	logic signed [QW-1:0] quo;
	logic signed [QW-1:0] quo_t;
	logic [7:0]           servo;

	always_ff @(posedge clk) begin
		if (ctl.ld3) begin
			done_s3 <= res_in.done;
			dir_s3  <= res_in.dir;
			pwm_s3  <= res_in.pwm;
			pp_s3   <= $signed({1'b0, cfg.gain_p}) * $signed(res_in.err);
			pi_s3   <= $signed({1'b0, cfg.gain_i}) * sum;
			pd_s3   <= $signed({1'b0, cfg.gain_d}) * $signed(res_in.deriv);
		end
	end

	// Servo angle: base minus correction, divided by 4096 toward zero, clamped.
	always_comb begin
		corr  = CW'(pp_s3) + CW'(pi_s3) + CW'(pd_s3);
		num   = $signed(CW'(SERVO_BASE_Q12)) - corr;
		quo   = num[CW-1:12];
		quo_t = (num[CW-1] && (num[11:0] != 12'd0)) ? quo + QW'(1) : quo;
		if (quo_t < $signed(QW'(SERVO_MIN))) begin
			servo = 8'(SERVO_MIN);
		end else if (quo_t > $signed(QW'(SERVO_MAX))) begin
			servo = 8'(SERVO_MAX);
		end else begin
			servo = quo_t[7:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ld4) begin
			res_s4.done  <= done_s3;
			res_s4.dir   <= dir_s3;
			res_s4.pwm   <= pwm_s3;
			res_s4.servo <= done_s3 ? SERVO_DONE : servo;
		end
	end

	assign res = res_s4;

endmodule

`default_nettype wire

FILE: rtl/heading_pid_steer_and_speed_top.sv
// Top level of the heading PID steering and speed controller.
// One control tick per request: the block takes a new tick every clock cycle while the output
// is not stalled and returns one result per tick, through the input register, error and integral
// stage, multiply stage and result register. The rate is set by the integral register, which adds
// and saturates each tick's error so the next tick sees it at once. Result requests are returned
// in order; a stalled output holds the pipeline behind it and the input stays ready as long as
// any stage is free. The user must write configuration through the APB port only while no tick
// is in flight; the block itself does not enforce it. No memory needs clearing after reset.
`default_nettype none

module heading_pid_steer_and_speed_top import hpss_pkg::*; #(
	parameter int SUM_WIDTH = SUM_WIDTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// Configuration port.
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [ADDR_WIDTH-1:0] paddr,
	input  wire logic [DATA_WIDTH-1:0] pwdata,
	output logic      [DATA_WIDTH-1:0] prdata,
	output logic                       pready,
	// Tick requests.
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [31:0]           s_tdata,  // heading [12:0], pulse_count [28:13]
	input  wire logic                  s_tuser,  // restart [0]
	// Results.
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [23:0]                m_tdata,  // servo_angle [7:0], pwm_duty [15:8], motor_dir [17:16]
	output logic                       m_tuser   // done_res [0]
);

	cfg_t      cfg;
	pipe_ctl_t ctl;
	err_res_t  err_res;
	out_res_t  out_res;
	logic signed [SUM_WIDTH-1:0] sum;

	logic v_s1_q, v_s2_q, v_s3_q, v_s4_q;
	logic rdy1, rdy2, rdy3, rdy4;

	assign pready = 1'b1;

	// Stage handshake: each stage loads when it is empty or moving on.
	always_comb begin
		rdy4    = !v_s4_q || m_tready;
		rdy3    = !v_s3_q || rdy4;
		rdy2    = !v_s2_q || rdy3;
		rdy1    = !v_s1_q || rdy2;
		ctl.ld1 = s_tvalid && rdy1;
		ctl.ld2 = v_s1_q && rdy2;
		ctl.ld3 = v_s2_q && rdy3;
		ctl.ld4 = v_s3_q && rdy4;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q <= 1'b0;
			v_s2_q <= 1'b0;
			v_s3_q <= 1'b0;
			v_s4_q <= 1'b0;
		end else begin
			if (ctl.ld1) begin
				v_s1_q <= 1'b1;
			end else if (ctl.ld2) begin
				v_s1_q <= 1'b0;
			end
			if (ctl.ld2) begin
				v_s2_q <= 1'b1;
			end else if (ctl.ld3) begin
				v_s2_q <= 1'b0;
			end
			if (ctl.ld3) begin
				v_s3_q <= 1'b1;
			end else if (ctl.ld4) begin
				v_s3_q <= 1'b0;
			end
			if (ctl.ld4) begin
				v_s4_q <= 1'b1;
			end else if (m_tready) begin
				v_s4_q <= 1'b0;
			end
		end
	end

	hpss_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	hpss_err #(
		.SUM_WIDTH (SUM_WIDTH)
	) u_err (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.cfg         (cfg),
		.restart     (s_tuser),
		.heading     (s_tdata[12:0]),
		.pulse_count (s_tdata[28:13]),
		.res         (err_res),
		.sum         (sum)
	);

	hpss_mix #(
		.SUM_WIDTH (SUM_WIDTH)
	) u_mix (
		.clk    (clk),
		.ctl    (ctl),
		.cfg    (cfg),
		.res_in (err_res),
		.sum    (sum),
		.res    (out_res)
	);

	assign s_tready = rdy1;
	assign m_tvalid = v_s4_q;
	assign m_tdata  = {6'd0, out_res.dir, out_res.pwm, out_res.servo};
	assign m_tuser  = out_res.done;

endmodule

`default_nettype wire

FILE: test/heading_pid_steer_and_speed_top_tb.sv
// Self-checking testbench for the heading PID steering and speed controller.
`timescale 1ns / 100ps

module heading_pid_steer_and_speed_top_tb;
	import hpss_pkg::*;

	localparam int INTEG_WIDTH = SUM_WIDTH_DEF;
	localparam longint INTEG_MAX = (64'sd1 <<< (INTEG_WIDTH - 1)) - 64'sd1;
	localparam longint INTEG_MIN = -INTEG_MAX - 64'sd1;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int RANDOM_PHASES = 10;
	localparam int PHASE_TICKS = 130;

	// One result item as the block reports it.
	typedef struct packed {
		logic [7:0] servo;
		logic [7:0] pwm;
		motor_dir_t dir;
		logic       done;
	} tick_result_t;

	typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_t;

	// One line of the directed plan: either a register write or a control tick.
	typedef struct packed {
		row_kind_t    kind;
		reg_idx_t     idx;
		logic [15:0]  value;
		logic         restart;
		logic [12:0]  heading;
		logic [15:0]  count;
		logic         typed;
		tick_result_t want;
	} plan_row_t;

	localparam tick_result_t NO_RES = '0;
	localparam tick_result_t STOP_RES = '{SERVO_DONE, 8'd0, DIR_STOP, 1'b1};
	localparam int PLAN_ROWS = 32;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [ADDR_WIDTH-1:0] paddr;
	logic [DATA_WIDTH-1:0] pwdata;
	logic [DATA_WIDTH-1:0] prdata;
	logic pready;
	logic s_tvalid;
	logic s_tready;
	logic [31:0] s_tdata;
	logic s_tuser;
	logic m_tvalid;
	logic m_tready;
	logic [23:0] m_tdata;
	logic m_tuser;

	// Predictor state and register copy.
	cfg_t ctl_regs;
	longint integ_acc;
	int last_err;
	tick_result_t awaited_ticks[$];
	int mismatches;
	int cycle_count;
	bit steady_flow;

	heading_pid_steer_and_speed_top #(.SUM_WIDTH(INTEG_WIDTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	// Directed plan: extremes, done ticks, heading wrap, reverse, crossed clamps.
	plan_row_t steer_plan [PLAN_ROWS] = '{
		'{ROW_TICK, REG_GAIN_P, 16'd0, 1'b0, 13'd0, 16'd0, 1'b1,
			'{8'd85, 8'd200, DIR_FORWARD, 1'b0}},
		'{ROW_TICK, REG_GAIN_P, 16'd0, 1'b0, 13'd0, 16'd1718, 1'b1, STOP_RES},
		'{ROW_TICK, REG_GAIN_P, 16'd0, 1'b0, 13'd0, 16'd65535, 1'b1, STOP_RES},
		'{ROW_TICK, REG_GAIN_P, 16'd0, 1'b0, 13'd0, 16'd1717, 1'b1,
			'{8'd85, 8'd80, DIR_FORWARD, 1'b0}},
		'{ROW_TICK, REG_GAIN_P, 16'd0, 1'b0, 13'd80, 16'd0, 1'b0, NO_RES},
		'{ROW_TICK, REG_GAIN_P, 16'd0, 1'b0, 13'd2880, 16'd100, 1'b0, NO_RES},
		'{ROW_TICK, REG_GAIN_P, 16'd0, 1'b0, 13'd2881, 16'd200, 1'b0, NO_RES},
		'{ROW_TICK, REG_GAIN_P, 16'd0, 1'b0, 13'd5759, 16'd300, 1'b0, NO_RES},
		'{ROW_TICK, REG_GAIN_P, 16'd0, 1'b0, 13'd8191, 16'd400, 1'b0, NO_RES},
		'{ROW_TICK, REG_GAIN_P, 16'd0, 1'b1, 13'd0, 16'd500, 1'b0, NO_RES},
		'{ROW_WRITE, REG_GAIN_P, 16'd4095, 1'b0, 13'd0, 16'd0, 1'b0, NO_RES},
		'{ROW_WRITE, REG_GAIN_I, 16'd4095, 1'b0, 13'd0, 16'd0, 1'b0, NO_RES},
		'{ROW_WRITE, REG_GAIN_D, 16'd4095, 1'b0, 13'd0, 16'd0, 1'b0, NO_RES},
		'{ROW_TICK, REG_GAIN_P, 16'd0, 1'b0, 13'd2880, 16'd0, 1'b0, NO_RES},
		'{ROW_WRITE, REG_FACING_DEG, 16'd180, 1'b0, 13'd0, 16'd0, 1'b0, NO_RES},
		'{ROW_TICK, REG_GAIN_P, 16'd0, 1'b1, 13'd0, 16'd0, 1'b0, NO_RES},
		'{ROW_WRITE, REG_GO_FORWARD, 16'd0, 1'b0, 13'd0, 16'd0, 1'b0, NO_RES},
		'{ROW_TICK, REG_GAIN_P, 16'd0, 1'b1, 13'd0, 16'd0, 1'b1,
			'{8'd85, 8'd200, DIR_REVERSE, 1'b0}},
		'{ROW_WRITE, REG_FACING_DEG, 16'd511, 1'b0, 13'd0, 16'd0, 1'b0, NO_RES},
		'{ROW_TICK, REG_GAIN_P, 16'd0, 1'b1, 13'd0, 16'd0, 1'b0, NO_RES},
		'{ROW_WRITE, REG_GO_FORWARD, 16'd1, 1'b0, 13'd0, 16'd0, 1'b0, NO_RES},
		'{ROW_TICK, REG_GAIN_P, 16'd0, 1'b1, 13'd0, 16'd0, 1'b0, NO_RES},
		'{ROW_WRITE, REG_TARGET_PULSES, 16'd65535, 1'b0, 13'd0, 16'd0, 1'b0, NO_RES},
		'{ROW_WRITE, REG_PWM_MAX, 16'd0, 1'b0, 13'd0, 16'd0, 1'b0, NO_RES},
		'{ROW_WRITE, REG_PWM_MIN, 16'd255, 1'b0, 13'd0, 16'd0, 1'b0, NO_RES},
		'{ROW_TICK, REG_GAIN_P, 16'd0, 1'b1, 13'd8176, 16'd0, 1'b1,
			'{8'd85, 8'd255, DIR_FORWARD, 1'b0}},
		'{ROW_TICK, REG_GAIN_P, 16'd0, 1'b0, 13'd8176, 16'd65534, 1'b1,
			'{8'd85, 8'd255, DIR_FORWARD, 1'b0}},
		'{ROW_TICK, REG_GAIN_P, 16'd0, 1'b0, 13'd8176, 16'd65535, 1'b1, STOP_RES},
		'{ROW_WRITE, REG_PWM_MIN, 16'd0, 1'b0, 13'd0, 16'd0, 1'b0, NO_RES},
		'{ROW_WRITE, REG_PWM_MAX, 16'd255, 1'b0, 13'd0, 16'd0, 1'b0, NO_RES},
		'{ROW_WRITE, REG_TARGET_PULSES, 16'd0, 1'b0, 13'd0, 16'd0, 1'b0, NO_RES},
		'{ROW_TICK, REG_GAIN_P, 16'd0, 1'b0, 13'd0, 16'd0, 1'b1, STOP_RES}
	};

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Watchdog on the total run length.
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Setpoint in whole degrees from the current register copy.
	function automatic int setpoint_deg();
		int sp;
		sp = ctl_regs.facing_deg;
		if (!ctl_regs.go_forward) begin
			sp += 180;
			if (sp > 360)
				sp -= 360;
		end
		return sp;
	endfunction

	// Steering and speed result of one tick; advances the integral and last error.
	function automatic tick_result_t predict_tick(logic restart, logic [12:0] heading,
			logic [15:0] count);
		tick_result_t res;
		int err;
		int duty;
		longint deriv;
		longint corr;
		longint servo;
		if (restart) begin
			integ_acc = 0;
			last_err = 0;
		end
		if (count >= ctl_regs.target_pulses)
			return STOP_RES;

		// Heading error, wrapped once and saturated to 13 bits.
		err = int'(heading) - setpoint_deg() * 16;
		if (err > 2880)
			err -= 5760;
		if (err < -2880)
			err += 5760;
		if (err > 4095)
			err = 4095;
		if (err < -4096)
			err = -4096;

		// Saturating integral, then the PID sum in 1/4096 degree.
		integ_acc += err;
		if (integ_acc > INTEG_MAX)
			integ_acc = INTEG_MAX;
		if (integ_acc < INTEG_MIN)
			integ_acc = INTEG_MIN;
		deriv = longint'(err) - longint'(last_err);
		corr = longint'(ctl_regs.gain_p) * err + longint'(ctl_regs.gain_i) * integ_acc
			+ longint'(ctl_regs.gain_d) * deriv;
		servo = (longint'(SERVO_BASE_Q12) - corr) / 64'sd4096;
		if (servo < SERVO_MIN)
			servo = SERVO_MIN;
		if (servo > SERVO_MAX)
			servo = SERVO_MAX;

		// Duty from remaining distance, upper clamp first.
		duty = (int'(ctl_regs.target_pulses) - int'(count)) >>> 1;
		if (duty > int'(ctl_regs.pwm_max))
			duty = ctl_regs.pwm_max;
		if (duty < int'(ctl_regs.pwm_min))
			duty = ctl_regs.pwm_min;

		last_err = err;
		res.servo = servo[7:0];
		res.pwm = duty[7:0];
		res.dir = ctl_regs.go_forward ? DIR_FORWARD : DIR_REVERSE;
		res.done = 1'b0;
		return res;
	endfunction

	// Current register value as it should read back.
	function automatic logic [DATA_WIDTH-1:0] reg_view(reg_idx_t idx);
		case (idx)
			REG_GAIN_P:        return DATA_WIDTH'(ctl_regs.gain_p);
			REG_GAIN_I:        return DATA_WIDTH'(ctl_regs.gain_i);
			REG_GAIN_D:        return DATA_WIDTH'(ctl_regs.gain_d);
			REG_FACING_DEG:    return DATA_WIDTH'(ctl_regs.facing_deg);
			REG_GO_FORWARD:    return DATA_WIDTH'(ctl_regs.go_forward);
			REG_TARGET_PULSES: return DATA_WIDTH'(ctl_regs.target_pulses);
			REG_PWM_MAX:       return DATA_WIDTH'(ctl_regs.pwm_max);
			default:           return DATA_WIDTH'(ctl_regs.pwm_min);
		endcase
	endfunction

	// Drop the tick request and wait until every result is back.
	task automatic drain();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (awaited_ticks.size() != 0)
			@(posedge clk);
	endtask

	// Register write, optionally with junk in the unused upper bits.
	task automatic write_reg(reg_idx_t idx, logic [15:0] value, bit junk);
		logic [DATA_WIDTH-1:0] data;
		data = DATA_WIDTH'(value);
		if (junk)
			data[31:16] = 16'($urandom);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 2'b00};
		pwdata = data;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_GAIN_P:        ctl_regs.gain_p = data[11:0];
			REG_GAIN_I:        ctl_regs.gain_i = data[11:0];
			REG_GAIN_D:        ctl_regs.gain_d = data[11:0];
			REG_FACING_DEG:    ctl_regs.facing_deg = data[8:0];
			REG_GO_FORWARD:    ctl_regs.go_forward = data[0];
			REG_TARGET_PULSES: ctl_regs.target_pulses = data[15:0];
			REG_PWM_MAX:       ctl_regs.pwm_max = data[7:0];
			default:           ctl_regs.pwm_min = data[7:0];
		endcase
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	// Register read compared with the register copy.
	task automatic check_reg(reg_idx_t idx);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = {idx, 2'b00};
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== reg_view(idx)) begin
			$error("register %s: expected %0d, got %0d", idx.name(), reg_view(idx), prdata);
			mismatches++;
		end
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	// Whole register set written once the block is idle, then read back.
	task automatic load_setup(cfg_t c);
		reg_idx_t idx;
		drain();
		write_reg(REG_GAIN_P, 16'(c.gain_p), 1'b1);
		write_reg(REG_GAIN_I, 16'(c.gain_i), 1'b1);
		write_reg(REG_GAIN_D, 16'(c.gain_d), 1'b1);
		write_reg(REG_FACING_DEG, 16'(c.facing_deg), 1'b1);
		write_reg(REG_GO_FORWARD, 16'(c.go_forward), 1'b1);
		write_reg(REG_TARGET_PULSES, c.target_pulses, 1'b1);
		write_reg(REG_PWM_MAX, 16'(c.pwm_max), 1'b1);
		write_reg(REG_PWM_MIN, 16'(c.pwm_min), 1'b1);
		idx = idx.first();
		do begin
			check_reg(idx);
			idx = idx.next();
		end while (idx != idx.first());
	endtask

	// One tick request; the expectation is queued when it is accepted.
	task automatic send_tick(logic restart, logic [12:0] heading, logic [15:0] count,
			bit typed = 1'b0, tick_result_t want = NO_RES);
		int gap;
		tick_result_t res;
		gap = steady_flow ? 0 : $urandom_range(0, 9);
		@(negedge clk);
		if (gap != 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser = restart;
		s_tdata = {3'b000, count, heading};
		do @(posedge clk); while (!s_tready);
		res = predict_tick(restart, heading, count);
		awaited_ticks.push_back(typed ? want : res);
	endtask

	// A move: usually a restart, heading held near the setpoint, count climbing to the target.
	task automatic run_move(inout int sent);
		int sp;
		int count;
		int step_max;
		int drift;
		int h;
		int stops;
		sp = setpoint_deg();
		count = ($urandom_range(0, 3) == 0) ? $urandom_range(0, ctl_regs.target_pulses) : 0;
		step_max = ctl_regs.target_pulses / 12 + 1;
		drift = $urandom_range(0, 800) - 400;
		stops = 0;
		for (int n = 0; n < 40; n++) begin
			h = sp * 16 + drift + $urandom_range(0, 64) - 32;
			h = ((h % 5760) + 5760) % 5760;
			drift += $urandom_range(0, 60) - 30;
			send_tick(n == 0 && $urandom_range(0, 7) != 0, 13'(h),
				16'((count > 65535) ? 65535 : count));
			sent++;
			if (count >= ctl_regs.target_pulses) begin
				stops++;
				if (stops > 1)
					break;
			end
			count += $urandom_range(0, step_max);
		end
	endtask

	// Result side: random stalls, each accepted result checked against the oldest expectation.
	initial begin : result_check
		int stall;
		tick_result_t got;
		tick_result_t want;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = steady_flow ? 0 : $urandom_range(0, 9);
			@(negedge clk);
			if (stall != 0) begin
				m_tready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready = 1'b1;
			do @(posedge clk); while (!m_tvalid);
			got.servo = m_tdata[7:0];
			got.pwm = m_tdata[15:8];
			got.dir = motor_dir_t'(m_tdata[17:16]);
			got.done = m_tuser;
			if (awaited_ticks.size() == 0) begin
				$error("result with no tick outstanding: %h", m_tdata);
				mismatches++;
			end else begin
				want = awaited_ticks.pop_front();
				if (got.servo !== want.servo) begin
					$error("servo_angle: expected %0d, got %0d", want.servo, got.servo);
					mismatches++;
				end
				if (got.pwm !== want.pwm) begin
					$error("pwm_duty: expected %0d, got %0d", want.pwm, got.pwm);
					mismatches++;
				end
				if (got.dir !== want.dir) begin
					$error("motor_dir: expected %0d, got %0d", want.dir, got.dir);
					mismatches++;
				end
				if (got.done !== want.done) begin
					$error("done_res: expected %0d, got %0d", want.done, got.done);
					mismatches++;
				end
			end
		end
	end

	// Stimulus: directed plan, integral saturation run, then random phases.
	initial begin : tick_source
		cfg_t c;
		int sent;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		mismatches = 0;
		steady_flow = 1'b0;
		ctl_regs = '{GAIN_P_RST, GAIN_I_RST, GAIN_D_RST, FACING_RST, GO_FORWARD_RST,
			TARGET_PULSES_RST, PWM_MAX_RST, PWM_MIN_RST};
		integ_acc = 0;
		last_err = 0;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed plan.
		foreach (steer_plan[i]) begin
			if (steer_plan[i].kind == ROW_WRITE) begin
				drain();
				write_reg(steer_plan[i].idx, steer_plan[i].value, 1'b0);
			end else begin
				send_tick(steer_plan[i].restart, steer_plan[i].heading, steer_plan[i].count,
					steer_plan[i].typed, steer_plan[i].want);
			end
		end

		// Drive the integral into its positive limit, then walk it back down through the
		// window where the servo is not clamped, so saturation shows in the results.
		load_setup('{12'd0, 12'd1, 12'd0, 9'd0, 1'b1, 16'd65535, 8'd200, 8'd80});
		steady_flow = 1'b1;
		send_tick(1'b1, 13'd2880, 16'd0);
		repeat (2950)
			send_tick(1'b0, 13'd2880, 16'($urandom_range(0, 1000)));
		repeat (3050)
			send_tick(1'b0, 13'd2881, 16'($urandom_range(0, 1000)));

		// Random phases, each with its own register setting.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			if (p == 0) begin
				c = '{12'd4095, 12'd4095, 12'd4095, 9'd511, 1'b0, 16'd65535, 8'd255, 8'd255};
			end else if (p == 1) begin
				c = '{12'd0, 12'd0, 12'd0, 9'd0, 1'b0, 16'd0, 8'd0, 8'd0};
			end else begin
				c.gain_p = ($urandom_range(0, 4) == 0) ? 12'($urandom) : 12'($urandom_range(0, 1023));
				c.gain_i = ($urandom_range(0, 4) == 0) ? 12'($urandom) : 12'($urandom_range(0, 24));
				c.gain_d = ($urandom_range(0, 4) == 0) ? 12'($urandom) : 12'($urandom_range(0, 1023));
				c.facing_deg = ($urandom_range(0, 4) == 0) ? 9'($urandom) : 9'($urandom_range(0, 359));
				c.go_forward = 1'($urandom);
				c.target_pulses = ($urandom_range(0, 4) == 0) ? 16'($urandom)
					: 16'($urandom_range(20, 3000));
				c.pwm_max = 8'($urandom);
				c.pwm_min = 8'($urandom_range(0, 120));
			end
			load_setup(c);
			steady_flow = (p % 4 == 3);
			sent = 0;
			while (sent < PHASE_TICKS) begin
				if ($urandom_range(0, 4) == 0) begin
					// Noise: any field value at all.
					send_tick(1'($urandom), 13'($urandom), 16'($urandom));
					sent++;
				end else begin
					run_move(sent);
				end
			end
		end

		drain();
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
